// File: hdl/mcdt_pkg.sv
// ============================================================================
// mcdt_pkg
// Shared types and constants for the multi-channel delay timer bank.
// ============================================================================
package mcdt_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WORD_W       = 32;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = 1;
    localparam int FIFO_CNT_W   = 2;

    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 104;

    typedef enum logic [2:0] {
        OP_TICK          = 3'd0,
        OP_START         = 3'd1,
        OP_STOP          = 3'd2,
        OP_RESTART       = 3'd3,
        OP_SET_DELAY     = 3'd4,
        OP_QUERY         = 3'd5,
        OP_QUERY_RESTART = 3'd6
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CH_W-1:0]    channel;
        logic               in_range;
        logic [WORD_W-1:0]  delay_ticks;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]  counter_now;
        logic               channel_enabled;
        logic [WORD_W-1:0]  delay_setting;
        logic [WORD_W-1:0]  ticks_remaining;
        logic               expired_if_enabled;
        logic               expired;
    } res_t;

endpackage

// File: hdl/mcdt_front.sv
// ============================================================================
// mcdt_front
// Accepts command words, decodes the operation and checks the channel range.
// ============================================================================
module mcdt_front (
    input  logic [2:0]                   op_raw,
    input  logic [mcdt_pkg::CH_W-1:0]    channel,
    input  logic [mcdt_pkg::WORD_W-1:0]  delay_ticks,
    output mcdt_pkg::cmd_t               cmd
);
    import mcdt_pkg::*;

    always_comb begin
        cmd.channel     = channel;
        cmd.delay_ticks = delay_ticks;
        cmd.in_range    = (32'(channel) < NUM_CHANNELS);
        case (op_raw)
            OP_TICK:          cmd.op = OP_TICK;
            OP_START:         cmd.op = OP_START;
            OP_STOP:          cmd.op = OP_STOP;
            OP_RESTART:       cmd.op = OP_RESTART;
            OP_SET_DELAY:     cmd.op = OP_SET_DELAY;
            OP_QUERY:         cmd.op = OP_QUERY;
            OP_QUERY_RESTART: cmd.op = OP_QUERY_RESTART;
            default:          cmd.op = OP_QUERY;
        endcase
    end

endmodule

// File: hdl/mcdt_fifo.sv
// ============================================================================
// mcdt_fifo
// Short command queue between the decode front and the execution back end.
// ============================================================================
module mcdt_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mcdt_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mcdt_pkg::cmd_t  head_cmd
);
    import mcdt_pkg::*;

    cmd_t                   mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/mcdt_exec.sv
// ============================================================================
// mcdt_exec
// Holds the tick counter and channel state, reports status and applies commands.
// ============================================================================
module mcdt_exec (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  mcdt_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            res_valid,
    input  logic            res_ready,
    output mcdt_pkg::res_t  res
);
    import mcdt_pkg::*;

    logic [WORD_W-1:0]    counter_reg, counter_next;
    logic [WORD_W-1:0]    stamp_reg  [NUM_CHANNELS];
    logic [WORD_W-1:0]    delay_reg  [NUM_CHANNELS];
    logic                 enable_reg [NUM_CHANNELS];
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;

    logic [CH_IDX_W-1:0]  idx;
    logic [WORD_W-1:0]    rd_stamp;
    logic [WORD_W-1:0]    rd_delay;
    logic                 rd_enable;
    logic [WORD_W-1:0]    elapsed;
    logic [WORD_W:0]      diff;
    logic                 expired;

    assign idx       = cmd.channel[CH_IDX_W-1:0];
    assign cmd_pop   = cmd_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        rd_stamp  = cmd.in_range ? stamp_reg[idx]  : '0;
        rd_delay  = cmd.in_range ? delay_reg[idx]  : '0;
        rd_enable = cmd.in_range ? enable_reg[idx] : 1'b0;
        elapsed   = counter_reg - rd_stamp;
        diff      = {1'b0, rd_delay} - {1'b0, elapsed};
        expired   = cmd.in_range && diff[WORD_W];

        out_next.expired            = expired;
        out_next.expired_if_enabled = expired && rd_enable;
        out_next.ticks_remaining    = expired ? '0 : diff[WORD_W-1:0];
        out_next.delay_setting      = rd_delay;
        out_next.channel_enabled    = rd_enable;
        out_next.counter_now        = counter_reg;

        counter_next = counter_reg;
        if (cmd_pop && cmd.op == OP_TICK) begin
            counter_next = counter_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd_pop) begin
            out_valid_next = 1'b1;
        end else if (res_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                stamp_reg[i]  <= '0;
                delay_reg[i]  <= '0;
                enable_reg[i] <= 1'b0;
            end
        end else begin
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
            if (cmd_pop && cmd.in_range) begin
                case (cmd.op)
                    OP_START: begin
                        stamp_reg[idx]  <= counter_reg;
                        enable_reg[idx] <= 1'b1;
                    end
                    OP_STOP: begin
                        enable_reg[idx] <= 1'b0;
                    end
                    OP_RESTART, OP_QUERY_RESTART: begin
                        stamp_reg[idx] <= counter_reg;
                    end
                    OP_SET_DELAY: begin
                        delay_reg[idx] <= cmd.delay_ticks;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: hdl/multi_channel_delay_timer_top.sv
// ============================================================================
// multi_channel_delay_timer_top
// Bank of delay channels sharing one 32-bit tick counter that advances on tick commands.
// ============================================================================
// Each command word names an operation and a channel and returns exactly one
// status word, holding the channel's state and the counter as they stood
// before the command. A command enters a two-entry queue in the cycle it is
// accepted and is executed from the head of the queue; the execution
// unit reads and updates the channel registers in the same cycle, so one
// command per cycle is sustained while the result side keeps taking words,
// and each status word is held in a register. The input side keeps
// accepting while the queue has room, even while a result waits to be taken.
module multi_channel_delay_timer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // op [2:0], channel [5:3], delay_ticks [37:6], zero fill [39:38]
    input  logic [mcdt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // expired [0], expired_if_enabled [1], ticks_remaining [33:2],
    // delay_setting [65:34], channel_enabled [66], counter_now [98:67],
    // zero fill [103:99]
    output logic [mcdt_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import mcdt_pkg::*;

    cmd_t  front_cmd;
    cmd_t  head_cmd;
    res_t  res;
    logic  fifo_full;
    logic  fifo_not_empty;
    logic  cmd_pop;
    logic  push;

    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && !fifo_full;

    mcdt_front u_front (
        .op_raw      (s_axis_tdata[2:0]),
        .channel     (s_axis_tdata[5:3]),
        .delay_ticks (s_axis_tdata[37:6]),
        .cmd         (front_cmd)
    );

    mcdt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .not_empty (fifo_not_empty),
        .head_cmd  (head_cmd)
    );

    mcdt_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fifo_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {5'b0, res.counter_now, res.channel_enabled, res.delay_setting,
                           res.ticks_remaining, res.expired_if_enabled, res.expired};

endmodule

// File: sim/multi_channel_delay_timer_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// multi_channel_delay_timer_top_test
// Self-checking bench for the delay timer bank. Command words are queued up
// front and sent in random bursts. Each accepted command updates a local
// copy of the counter and channel registers, and the status it should return
// is stored. Every status word taken from the result side is compared field
// by field with the oldest stored status. The result side stalls on its own
// pattern and holds off once for a long stretch so that the input backs up.
// ============================================================================
module multi_channel_delay_timer_top_test;

    import mcdt_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_CMDS = 1930;
    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    logic [S_TDATA_W-1:0]  cmd_queue[$];
    res_t                  status_expected[$];

    logic [WORD_W-1:0]     tick_count;
    logic [WORD_W-1:0]     chan_stamp  [NUM_CHANNELS];
    logic [WORD_W-1:0]     chan_delay  [NUM_CHANNELS];
    logic                  chan_enable [NUM_CHANNELS];

    int                    cmds_total;
    int                    cmds_sent     = 0;
    int                    status_seen   = 0;
    int                    mismatches    = 0;
    int                    cycle_count   = 0;

    multi_channel_delay_timer_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [S_TDATA_W-1:0] cmd_word(logic [2:0] op, logic [2:0] ch,
                                                      logic [WORD_W-1:0] dly);
        return {2'b00, dly, ch, op};
    endfunction

    // Returns the status a command should report and applies it to the
    // local copy of the timer bank.
    function automatic res_t timer_step(logic [S_TDATA_W-1:0] word);
        logic [2:0]        op;
        logic [2:0]        ch;
        logic [WORD_W-1:0] dly_in;
        logic [WORD_W-1:0] elapsed;
        res_t              st;
        op     = word[2:0];
        ch     = word[5:3];
        dly_in = word[37:6];
        st     = '0;
        st.counter_now = tick_count;
        if (ch < NUM_CHANNELS) begin
            elapsed            = tick_count - chan_stamp[ch];
            st.delay_setting   = chan_delay[ch];
            st.channel_enabled = chan_enable[ch];
            if (elapsed > chan_delay[ch]) begin
                st.expired = 1'b1;
            end else begin
                st.ticks_remaining = chan_delay[ch] - elapsed;
            end
            st.expired_if_enabled = st.expired & chan_enable[ch];
        end
        if (op == OP_TICK) begin
            tick_count = tick_count + 1'b1;
        end else if (ch < NUM_CHANNELS) begin
            case (op)
                OP_START: begin
                    chan_stamp[ch]  = tick_count;
                    chan_enable[ch] = 1'b1;
                end
                OP_STOP: begin
                    chan_enable[ch] = 1'b0;
                end
                OP_RESTART, OP_QUERY_RESTART: begin
                    chan_stamp[ch] = tick_count;
                end
                OP_SET_DELAY: begin
                    chan_delay[ch] = dly_in;
                end
                default: begin
                end
            endcase
        end
        return st;
    endfunction

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    function automatic logic [WORD_W-1:0] random_delay();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
            return $urandom_range(0, 40);
        end else if (pick < 16) begin
            return $urandom;
        end else if (pick < 18) begin
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
        return '0;
    endfunction

    function automatic logic [2:0] random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return OP_TICK;
        if (pick < 40) return OP_START;
        if (pick < 48) return OP_STOP;
        if (pick < 56) return OP_RESTART;
        if (pick < 70) return OP_SET_DELAY;
        if (pick < 86) return OP_QUERY;
        if (pick < 96) return OP_QUERY_RESTART;
        return OP_UNUSED;
    endfunction

    initial begin
        logic [2:0]        ch;
        logic [WORD_W-1:0] dly;
        int                n;
        int                target;

        tick_count = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            chan_stamp[k]  = '0;
            chan_delay[k]  = '0;
            chan_enable[k] = 1'b0;
        end

        // Zero delay, expiry with and without enable, largest delay, the
        // unused op code and alternating bit patterns in the delay field.
        cmd_queue.push_back(cmd_word(OP_QUERY,         3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_SET_DELAY,     3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_START,         3'd0, 32'hFFFF_FFFF));
        cmd_queue.push_back(cmd_word(OP_QUERY,         3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_TICK,          3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_QUERY,         3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_STOP,          3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_QUERY,         3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_SET_DELAY,     3'd7, 32'hFFFF_FFFF));
        cmd_queue.push_back(cmd_word(OP_START,         3'd7, 32'h0));
        cmd_queue.push_back(cmd_word(OP_QUERY,         3'd7, 32'h0));
        cmd_queue.push_back(cmd_word(OP_SET_DELAY,     3'd3, 32'h2));
        cmd_queue.push_back(cmd_word(OP_RESTART,       3'd3, 32'h0));
        cmd_queue.push_back(cmd_word(OP_TICK,          3'd5, 32'h0));
        cmd_queue.push_back(cmd_word(OP_TICK,          3'd2, 32'h0));
        cmd_queue.push_back(cmd_word(OP_QUERY_RESTART, 3'd3, 32'h0));
        cmd_queue.push_back(cmd_word(OP_TICK,          3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_TICK,          3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_TICK,          3'd0, 32'h0));
        cmd_queue.push_back(cmd_word(OP_QUERY,         3'd3, 32'h0));
        cmd_queue.push_back(cmd_word(OP_UNUSED,        3'd3, 32'hFFFF_FFFF));
        cmd_queue.push_back(cmd_word(OP_SET_DELAY,     3'd5, 32'hAAAA_AAAA));
        cmd_queue.push_back(cmd_word(OP_SET_DELAY,     3'd6, 32'h5555_5555));
        cmd_queue.push_back(cmd_word(OP_START,         3'd5, 32'h0));
        cmd_queue.push_back(cmd_word(OP_QUERY,         3'd5, 32'h0));

        // Most of the random part runs whole timing sequences on one channel;
        // the rest is a loose mix of commands.
        target = cmd_queue.size() + RANDOM_CMDS;
        while (cmd_queue.size() < target) begin
            ch = 3'($urandom_range(0, NUM_CHANNELS - 1));
            if ($urandom_range(0, 2) != 0) begin
                dly = $urandom_range(0, 12);
                n   = $urandom_range(0, dly + 3);
                cmd_queue.push_back(cmd_word(OP_SET_DELAY, ch, dly));
                cmd_queue.push_back(cmd_word($urandom_range(0, 1) ? OP_START : OP_RESTART,
                                             ch, $urandom));
                for (int k = 0; k < n; k++) begin
                    cmd_queue.push_back(cmd_word(OP_TICK, 3'($urandom_range(0, 7)), $urandom));
                end
                cmd_queue.push_back(cmd_word($urandom_range(0, 1) ? OP_QUERY : OP_QUERY_RESTART,
                                             ch, $urandom));
                if ($urandom_range(0, 3) == 0) begin
                    cmd_queue.push_back(cmd_word(OP_STOP, ch, $urandom));
                end
            end else begin
                cmd_queue.push_back(cmd_word(random_op(), ch, random_delay()));
            end
        end
        cmds_total = cmd_queue.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmds_sent < cmds_total || status_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Command driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                status_expected.push_back(timer_step(s_axis_tdata));
                cmds_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cmd_queue.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Status monitor and result-side stall pattern.
    int   stall_mode  = 0;
    int   mode_cycles = 0;
    int   hold_left   = 0;
    bit   held_once   = 1'b0;
    res_t want;
    res_t got;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                status_seen++;
                got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
                if (status_expected.size() == 0) begin
                    mismatches++;
                    $error("status word with none expected: %h", m_axis_tdata);
                end else begin
                    want = status_expected.pop_front();
                    check_field("expired", WORD_W'(want.expired), WORD_W'(got.expired));
                    check_field("expired_if_enabled", WORD_W'(want.expired_if_enabled),
                                WORD_W'(got.expired_if_enabled));
                    check_field("ticks_remaining", want.ticks_remaining, got.ticks_remaining);
                    check_field("delay_setting", want.delay_setting, got.delay_setting);
                    check_field("channel_enabled", WORD_W'(want.channel_enabled),
                                WORD_W'(got.channel_enabled));
                    check_field("counter_now", want.counter_now, got.counter_now);
                    check_field("zero fill", '0,
                                WORD_W'(m_axis_tdata[M_TDATA_W-1:$bits(res_t)]));
                end
                if (status_seen == 300 && !held_once) begin
                    held_once = 1'b1;
                    hold_left = 400;
                end
            end
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = $urandom_range(20, 120);
            end else begin
                mode_cycles--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
